// ===== src/hacc_pkg.sv =====
// ----------------------------------------------------------------------------
// hacc_pkg
// Shared types and constants of the histogram accumulator.
// ----------------------------------------------------------------------------
package hacc_pkg;

    localparam int NBINS_DEFAULT = 1024;

    localparam logic [2:0] KIND_FILL    = 3'd0;
    localparam logic [2:0] KIND_REPEAT  = 3'd1;
    localparam logic [2:0] KIND_READ    = 3'd2;
    localparam logic [2:0] KIND_PCTL    = 3'd3;
    localparam logic [2:0] KIND_RANGE   = 3'd4;
    localparam logic [2:0] KIND_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NEG   = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CFG_RANGE_LOW = 2'd0;
    localparam logic [1:0] CFG_BIN_SCALE = 2'd1;
    localparam logic [1:0] CFG_BINS      = 2'd2;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [61:0] MAX62 = {62{1'b1}};

    // Item queued between front and back
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic signed [15:0] weight;
        logic signed [11:0] bin_first;
        logic signed [11:0] bin_last;
        logic [15:0]        fraction;
    } item_t;

    function automatic logic [47:0] sat48(input logic [48:0] s);
        sat48 = s[48] ? MAX48 : s[47:0];
    endfunction

endpackage

// ===== src/hacc_queue.sv =====
// ----------------------------------------------------------------------------
// hacc_queue
// Small FIFO between the front end and the execution engine.
// ----------------------------------------------------------------------------
module hacc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hacc_pkg::item_t   push_item,
    output logic              full,
    input  logic              pop,
    output hacc_pkg::item_t   head,
    output logic              not_empty
);

    hacc_pkg::item_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full      = cnt_reg == 3'd4;
    assign not_empty = cnt_reg != 3'd0;
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop && not_empty)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'b0, push && !full} - {2'b0, pop && not_empty};
        end
    end

endmodule

// ===== src/hacc_engine.sv =====
// ----------------------------------------------------------------------------
// hacc_engine
// Executes one item at a time: fill pipeline, bin walks and clear sweep.
// ----------------------------------------------------------------------------
module hacc_engine
#(
    parameter int NBINS = hacc_pkg::NBINS_DEFAULT,
    parameter int AW    = (NBINS > 1) ? $clog2(NBINS) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [31:0]  range_low,
    input  logic [31:0]         bin_scale,
    input  logic [10:0]         bins_in_use,
    input  logic                cfg_busy_n,
    input  hacc_pkg::item_t     item,
    input  logic                item_valid,
    output logic                item_pop,
    output logic                idle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [47:0]         bin_total,
    output logic [61:0]         bin_squares,
    output logic signed [11:0]  found_bin,
    output logic [47:0]         weight_sum,
    output logic signed [63:0]  weighted_value_sum,
    output logic signed [31:0]  min_seen,
    output logic signed [31:0]  max_seen,
    output logic                any_filled
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MAP   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_WR    = 4'd5;
    localparam logic [3:0] S_QRD   = 4'd6;
    localparam logic [3:0] S_QDAT  = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_PWALK = 4'd9;
    localparam logic [3:0] S_CLR   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_PCHK  = 4'd12;

    localparam logic [16:0] NB17 = 17'(NBINS);

    logic [47:0] cnt_mem [NBINS];
    logic [61:0] sq_mem  [NBINS];
    logic [47:0] cnt_rd_reg;
    logic [61:0] sq_rd_reg;

    logic [3:0]  state_reg, state_next;
    hacc_pkg::item_t it_reg;
    logic [16:0] n_eff;
    logic [AW-1:0] addr_reg, addr_next;
    logic [16:0] idx_reg, idx_next;
    logic        mem_we;
    logic [47:0] mem_wc;
    logic [61:0] mem_ws;
    logic [AW-1:0] rd_addr;

    logic [47:0] uf_reg, of_reg, tw_reg, acc_reg, acc_next;
    logic [47:0] uf_next, of_next, tw_next;
    logic signed [63:0] twv_reg, twv_next;
    logic signed [31:0] mn_reg, mx_reg, mn_next, mx_next;
    logic        fl_reg, fl_next;
    logic [47:0] tot_reg, tot_next;
    logic [63:0] target_reg, target_next;
    logic        pass_reg, pass_next;

    logic [32:0] d_reg;
    logic [47:0] m_hi_reg;
    logic [47:0] m_lo_reg;
    logic [47:0] bin_reg;
    logic        uf_fill_reg;
    logic [15:0] amt;
    logic [61:0] sq_amt;
    logic signed [47:0] wv_reg;

    logic [1:0]  st_reg, st_next;
    logic [47:0] tot_o_reg, tot_o_next;
    logic [61:0] sq_o_reg, sq_o_next;
    logic signed [11:0] fb_reg, fb_next;

    logic signed [12:0] b1, b2, n13;

    assign n_eff = (bins_in_use == 11'd0) ? 17'd1 :
                   ({6'd0, bins_in_use} > NB17) ? NB17 : {6'd0, bins_in_use};
    assign n13 = 13'(n_eff);
    assign b1  = 13'(it_reg.bin_first);
    assign b2  = 13'(it_reg.bin_last);
    assign amt = it_reg.weight[15:0];
    assign sq_amt = (it_reg.kind == hacc_pkg::KIND_FILL) ?
                    62'({16'd0, amt} * {16'd0, amt}) : 62'(amt);

    assign item_pop = (state_reg == S_IDLE) && item_valid && cfg_busy_n;
    assign idle = (state_reg == S_IDLE) && !item_valid;
    assign out_valid = state_reg == S_OUT;

    assign status             = st_reg;
    assign bin_total          = tot_o_reg;
    assign bin_squares        = sq_o_reg;
    assign found_bin          = fb_reg;
    assign weight_sum         = tw_reg;
    assign weighted_value_sum = twv_reg;
    assign min_seen           = mn_reg;
    assign max_seen           = mx_reg;
    assign any_filled         = fl_reg;

    assign rd_addr = addr_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[addr_reg] <= mem_wc;
            sq_mem[addr_reg]  <= mem_ws;
        end
        cnt_rd_reg <= cnt_mem[rd_addr];
        sq_rd_reg  <= sq_mem[rd_addr];
    end

    // fill datapath: products registered before the bin sum
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            d_reg    <= 33'(item.value) - 33'(range_low);
            wv_reg   <= 48'(item.value) * 48'(item.weight);
        end
        if (state_reg == S_MUL)
        begin
            m_hi_reg <= {15'd0, d_reg[32] ? 33'd0 : d_reg} * {32'd0, bin_scale[31:16]};
            m_lo_reg <= ({15'd0, d_reg} * {32'd0, bin_scale[15:0]}) >> 16;
            uf_fill_reg <= d_reg[32];
        end
        if (state_reg == S_MAP)
        begin
            bin_reg <= m_hi_reg + m_lo_reg;
        end
    end

    always_comb
    begin
        logic signed [64:0] s65;
        logic [48:0] s49;
        logic [62:0] s63;
        state_next = state_reg;
        addr_next  = addr_reg;
        idx_next   = idx_reg;
        mem_we = 1'b0;
        mem_wc = '0;
        mem_ws = '0;
        uf_next = uf_reg; of_next = of_reg; tw_next = tw_reg; twv_next = twv_reg;
        mn_next = mn_reg; mx_next = mx_reg; fl_next = fl_reg;
        tot_next = tot_reg; target_next = target_reg; acc_next = acc_reg;
        pass_next = pass_reg;
        st_next = st_reg; tot_o_next = tot_o_reg; sq_o_next = sq_o_reg; fb_next = fb_reg;
        s65 = '0; s49 = '0; s63 = '0;
        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (32'(addr_reg) == NBINS - 1)
                begin
                    state_next = S_IDLE;
                    addr_next = '0;
                end
            end
            S_IDLE:
            begin
                if (item_pop)
                begin
                    st_next = hacc_pkg::ST_OK;
                    tot_o_next = '0;
                    sq_o_next = '0;
                    fb_next = '0;
                    state_next = S_OUT;
                    case (item.kind)
                        hacc_pkg::KIND_FILL, hacc_pkg::KIND_REPEAT:
                        begin
                            if (item.weight < 0)
                            begin
                                st_next = hacc_pkg::ST_NEG;
                            end
                            else if (item.weight != 0)
                            begin
                                state_next = S_MUL;
                            end
                        end
                        hacc_pkg::KIND_READ, hacc_pkg::KIND_PCTL, hacc_pkg::KIND_RANGE:
                        begin
                            state_next = S_QRD;
                        end
                        hacc_pkg::KIND_CLEAR:
                        begin
                            state_next = S_CLR;
                            addr_next = '0;
                            uf_next = '0; of_next = '0; tw_next = '0; twv_next = '0;
                            mn_next = '0; mx_next = '0; fl_next = 1'b0;
                        end
                        default:
                        begin
                            st_next = hacc_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_MAP;
            end
            S_MAP:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                // bin_reg valid; address the memory
                if (!uf_fill_reg && bin_reg < 48'(n_eff))
                begin
                    addr_next = AW'(bin_reg);
                    state_next = S_WR;
                end
                else
                begin
                    s49 = uf_fill_reg ? {1'b0, uf_reg} + 49'(amt) : {1'b0, of_reg} + 49'(amt);
                    if (uf_fill_reg)
                        uf_next = hacc_pkg::sat48(s49);
                    else
                        of_next = hacc_pkg::sat48(s49);
                    state_next = S_PCHK;
                end
            end
            S_WR:
            begin
                mem_we = 1'b1;
                mem_wc = hacc_pkg::sat48({1'b0, cnt_rd_reg} + 49'(amt));
                s63 = {1'b0, sq_rd_reg} + {1'b0, sq_amt};
                mem_ws = s63[62] ? hacc_pkg::MAX62 : s63[61:0];
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (!fl_reg)
                begin
                    mn_next = it_reg.value;
                    mx_next = it_reg.value;
                end
                else
                begin
                    if (it_reg.value < mn_reg) mn_next = it_reg.value;
                    if (it_reg.value > mx_reg) mx_next = it_reg.value;
                end
                fl_next = 1'b1;
                tw_next = hacc_pkg::sat48({1'b0, tw_reg} + 49'(amt));
                s65 = 65'(twv_reg) + 65'(wv_reg);
                if (s65[64] != s65[63])
                    twv_next = s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    twv_next = s65[63:0];
                state_next = S_OUT;
            end
            S_QRD:
            begin
                case (it_reg.kind)
                    hacc_pkg::KIND_READ:
                    begin
                        if (b1 == -13'sd1)
                        begin
                            tot_o_next = uf_reg;
                            state_next = S_OUT;
                        end
                        else if (b1 == n13)
                        begin
                            tot_o_next = of_reg;
                            state_next = S_OUT;
                        end
                        else if (b1 >= 0 && b1 < n13)
                        begin
                            addr_next = AW'(b1);
                            state_next = S_QDAT;
                        end
                        else
                        begin
                            st_next = hacc_pkg::ST_BAD;
                            state_next = S_OUT;
                        end
                    end
                    hacc_pkg::KIND_RANGE:
                    begin
                        if (b1 > b2 || b1 < -13'sd1 || b2 > n13)
                        begin
                            st_next = hacc_pkg::ST_BAD;
                            state_next = S_OUT;
                        end
                        else if (b1 == n13)
                        begin
                            tot_o_next = of_reg;
                            state_next = S_OUT;
                        end
                        else if (b2 == -13'sd1)
                        begin
                            tot_o_next = uf_reg;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            acc_next = (b1 == -13'sd1) ? uf_reg : '0;
                            if (b2 == n13)
                                acc_next = hacc_pkg::sat48({1'b0, acc_next} + {1'b0, of_reg});
                            idx_next = (b1 == -13'sd1) ? 17'd0 : 17'(b1);
                            tot_next = 48'((b2 == n13) ? n13 - 13'sd1 : b2);
                            addr_next = AW'(idx_next);
                            state_next = S_SUM;
                        end
                    end
                    default:
                    begin
                        // percentile: first pass totals, second pass searches
                        if (it_reg.fraction == 16'd0)
                        begin
                            st_next = hacc_pkg::ST_BAD;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            acc_next = uf_reg;
                            idx_next = '0;
                            addr_next = '0;
                            pass_next = 1'b0;
                            tot_next = 48'(n13 - 13'sd1);
                            state_next = S_SUM;
                        end
                    end
                endcase
            end
            S_QDAT:
            begin
                tot_o_next = cnt_rd_reg;
                sq_o_next  = sq_rd_reg;
                state_next = S_OUT;
            end
            S_SUM:
            begin
                // one read issued per cycle; data arrives next cycle
                state_next = S_PWALK;
                idx_next = idx_reg;
                addr_next = AW'(idx_reg);
            end
            S_PWALK:
            begin
                acc_next = hacc_pkg::sat48({1'b0, acc_reg} + {1'b0, cnt_rd_reg});
                if (it_reg.kind == hacc_pkg::KIND_PCTL && pass_reg &&
                    {acc_next, 16'd0} >= target_reg)
                begin
                    fb_next = 12'(idx_reg);
                    state_next = S_OUT;
                end
                else if (48'(idx_reg) == tot_reg)
                begin
                    if (it_reg.kind == hacc_pkg::KIND_RANGE)
                    begin
                        tot_o_next = acc_next;
                        state_next = S_OUT;
                    end
                    else if (pass_reg)
                    begin
                        fb_next = 12'(n13);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        acc_next = hacc_pkg::sat48({1'b0, acc_next} + {1'b0, of_reg});
                        target_next = 64'(it_reg.fraction) * 64'(acc_next);
                        state_next = S_OUT;
                        if (acc_next == '0)
                            st_next = hacc_pkg::ST_EMPTY;
                        else if ({uf_reg, 16'd0} >= target_next)
                            fb_next = -12'sd1;
                        else
                        begin
                            pass_next = 1'b1;
                            acc_next = uf_reg;
                            idx_next = '0;
                            addr_next = '0;
                            state_next = S_SUM;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 17'd1;
                    addr_next = AW'(idx_reg + 17'd1);
                end
            end
            S_CLR:
            begin
                mem_we = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (32'(addr_reg) == NBINS - 1)
                begin
                    addr_next = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
            it_reg <= item;
        tot_o_reg <= tot_o_next;
        sq_o_reg <= sq_o_next;
        fb_reg <= fb_next;
        st_reg <= st_next;
        acc_reg <= acc_next;
        tot_reg <= tot_next;
        target_reg <= target_next;
        idx_reg <= idx_next;
        pass_reg <= pass_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
            uf_reg <= '0; of_reg <= '0; tw_reg <= '0; twv_reg <= '0;
            mn_reg <= '0; mx_reg <= '0; fl_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            uf_reg <= uf_next; of_reg <= of_next; tw_reg <= tw_next;
            twv_reg <= twv_next; mn_reg <= mn_next; mx_reg <= mx_next;
            fl_reg <= fl_next;
        end
    end

endmodule

// ===== src/histogram_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// histogram_accumulator_top
// Weighted 1-D histogram with underflow/overflow counters and queries.
// ----------------------------------------------------------------------------
// Transactions run one at a time; the engine takes a transaction from the
// queue while idle, then: an in-range fill runs map multiply, bin sum, memory
// read-modify-write and totals; an underflow or overflow fill skips the memory
// read-modify-write; read bin reads the memory only for a bin in range; range
// sum sets up and then walks the selected bins; percentile totals the bins in
// use in a first walk and searches them in a second that stops at the target
// bin; clear sweeps all NBINS entries. The result then holds until out_ready.
// After reset a clearing pass over all NBINS entries runs before the first
// transaction is taken. A four-entry queue decouples input; config writes are
// taken only when the engine and queue are empty.
module histogram_accumulator_top
#(
    parameter int NBINS = hacc_pkg::NBINS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    input  logic signed [15:0] weight,
    input  logic signed [11:0] bin_first,
    input  logic signed [11:0] bin_last,
    input  logic [15:0]        fraction,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [47:0]        bin_total,
    output logic [61:0]        bin_squares,
    output logic signed [11:0] found_bin,
    output logic [47:0]        weight_sum,
    output logic signed [63:0] weighted_value_sum,
    output logic signed [31:0] min_seen,
    output logic signed [31:0] max_seen,
    output logic               any_filled
);

    logic signed [31:0] range_low_reg;
    logic [31:0] bin_scale_reg;
    logic [10:0] bins_reg;
    hacc_pkg::item_t in_item, head;
    logic full, not_empty, pop, idle;

    assign cfg_ready = idle;
    assign in_ready  = !full;
    assign in_item   = '{kind, value, weight, bin_first, bin_last, fraction};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg <= '0;
            bin_scale_reg <= 32'd65536;
            bins_reg      <= 11'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hacc_pkg::CFG_RANGE_LOW: range_low_reg <= cfg_data;
                hacc_pkg::CFG_BIN_SCALE: bin_scale_reg <= cfg_data;
                hacc_pkg::CFG_BINS:      bins_reg <= cfg_data[10:0];
                default:                 bins_reg <= bins_reg;
            endcase
        end
    end

    hacc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (in_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    hacc_engine #(.NBINS(NBINS)) u_engine
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .range_low          (range_low_reg),
        .bin_scale          (bin_scale_reg),
        .bins_in_use        (bins_reg),
        .cfg_busy_n         (!(cfg_valid && cfg_ready)),
        .item               (head),
        .item_valid         (not_empty),
        .item_pop           (pop),
        .idle               (idle),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .bin_total          (bin_total),
        .bin_squares        (bin_squares),
        .found_bin          (found_bin),
        .weight_sum         (weight_sum),
        .weighted_value_sum (weighted_value_sum),
        .min_seen           (min_seen),
        .max_seen           (max_seen),
        .any_filled         (any_filled)
    );

endmodule
